// File: design/tmts_pkg.sv
// ----------------------------------------------------------------------------
// tmts_pkg
// Shared types and constants of the tile map cell to tile source block.
// ----------------------------------------------------------------------------
package tmts_pkg;

  localparam int TILE_ID_W  = 16;
  localparam int CNT_W      = 12;
  localparam int WIDTH_W    = 13;
  localparam int ORIGIN_W   = 16;
  localparam int TS_W       = 56;
  localparam int TS_REGS    = 4;
  localparam int SEL_W      = 2;
  localparam int SRC_COL_W  = 8;
  localparam int SRC_ROW_W  = 16;
  localparam int SCREEN_W   = 22;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TILESET0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_ORIGIN_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_ORIGIN_Y = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DIV,
    ST_MULX,
    ST_MULY
  } tmts_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
  } tmts_pos_t;

  // step to the next cell in row-major order, row saturates
  function automatic tmts_pos_t tmts_advance(tmts_pos_t cur, logic [WIDTH_W-1:0] eff_w);
    tmts_pos_t          res;
    logic [WIDTH_W-1:0] nxt;
    nxt = {1'b0, cur.col} + WIDTH_W'(1);
    if (nxt >= eff_w) begin
      res.col = '0;
      res.row = (cur.row < CNT_MAX) ? cur.row + CNT_W'(1) : cur.row;
    end else begin
      res.col = nxt[CNT_W-1:0];
      res.row = cur.row;
    end
    return res;
  endfunction

endpackage

// File: design/tmts_if.sv
// ----------------------------------------------------------------------------
// tmts channel interfaces
// Valid/ready channels for cell requests, tile source results and config.
// ----------------------------------------------------------------------------
interface tmts_in_if;
  import tmts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TILE_ID_W-1:0] tile_id;
  logic                 restart;
  modport source (output valid, tile_id, restart, input ready);
  modport sink   (input valid, tile_id, restart, output ready);
endinterface

interface tmts_out_if;
  import tmts_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [SEL_W-1:0]           tileset_sel;
  logic [SRC_COL_W-1:0]       src_col;
  logic [SRC_ROW_W-1:0]       src_row;
  logic signed [SCREEN_W-1:0] screen_x;
  logic signed [SCREEN_W-1:0] screen_y;
  logic                       no_match;
  modport source (output valid, tileset_sel, src_col, src_row, screen_x, screen_y,
                  no_match, input ready);
  modport sink   (input valid, tileset_sel, src_col, src_row, screen_x, screen_y,
                  no_match, output ready);
endinterface

interface tmts_cfg_if;
  import tmts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TS_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/tilemap_cell_to_tile_source_core.sv
// ----------------------------------------------------------------------------
// tilemap_cell_to_tile_source_core
// Tracks the map cell position and turns each nonzero tile id into tileset
// number, source column/row inside the tileset image and screen position, or no_match.
// ----------------------------------------------------------------------------
//   port     | dir | carries
//   in_ch    | in  | tile_id, restart (one request per map cell)
//   out_ch   | out | tileset_sel, src_col, src_row, screen_x, screen_y, no_match
//   cfg_ch   | in  | index, data (register write, always ready)
//
// a matching id takes one tileset compare per cycle up to the hit, 16 steps of the
// restoring divider and two passes of the shared multiply-add; a miss scans every
// tileset and then gives a no_match result. The block returns to idle before the
// next request is taken, and an empty cell (id zero) only advances the cell position.
// rst_n is synchronous and clears state.
// a result waits in the output register; a new one is not loaded until it is taken.
module tilemap_cell_to_tile_source_core #(
  parameter int NUM_TILESETS    = 4,
  parameter int MAX_LAYER_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  tmts_in_if.sink     in_ch,
  tmts_out_if.source  out_ch,
  tmts_cfg_if.sink    cfg_ch
);
  import tmts_pkg::*;

  localparam int NUSED = (NUM_TILESETS < TS_REGS) ? NUM_TILESETS : TS_REGS;
  localparam int WCAP  = (MAX_LAYER_WIDTH < 4096) ? MAX_LAYER_WIDTH : 4096;
  localparam logic [SEL_W-1:0] LAST_TS = SEL_W'(NUSED - 1);

  tmts_state_t state_r, state_nxt;

  // configuration registers
  logic [TS_W-1:0]            tileset_r [TS_REGS];
  logic [WIDTH_W-1:0]         layer_width_r;
  logic signed [ORIGIN_W-1:0] origin_x_r;
  logic signed [ORIGIN_W-1:0] origin_y_r;

  tmts_pos_t pos_r, pos_nxt;

  logic [TILE_ID_W-1:0] id_r;
  logic [SEL_W-1:0]     scan_r;
  logic [SRC_COL_W-1:0] cols_r;
  logic [7:0]           tw_r;
  logic [7:0]           th_r;
  logic [SRC_ROW_W-1:0] quo_r;
  logic [SRC_COL_W-1:0] rem_r;
  logic [3:0]           step_r;
  logic signed [SCREEN_W-1:0] sx_r;

  logic                       out_valid_r;
  logic [SEL_W-1:0]           out_sel_r;
  logic [SRC_COL_W-1:0]       out_col_r;
  logic [SRC_ROW_W-1:0]       out_row_r;
  logic signed [SCREEN_W-1:0] out_x_r;
  logic signed [SCREEN_W-1:0] out_y_r;
  logic                       out_nm_r;

  logic in_acc, slot_free, hit, load_nm, load_res, finish;
  logic [WIDTH_W-1:0]   eff_w;
  logic [TS_W-1:0]      ts_cur;
  logic [TILE_ID_W-1:0] ts_first, ts_count, idx;
  logic [SRC_COL_W:0]   rem_ext, rem_sub;
  logic                 div_ge;
  logic [CNT_W-1:0]     mul_a;
  logic [7:0]           mul_b;
  logic signed [ORIGIN_W-1:0] mul_org;
  logic signed [SCREEN_W-1:0] mul_sum;
  tmts_pos_t base_pos;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    if (layer_width_r == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (layer_width_r > WIDTH_W'(WCAP)) begin
      eff_w = WIDTH_W'(WCAP);
    end else begin
      eff_w = layer_width_r;
    end
  end

  // one tileset range compare per cycle
  assign ts_cur   = tileset_r[scan_r];
  assign ts_first = ts_cur[15:0];
  assign ts_count = ts_cur[31:16];
  assign idx      = id_r - ts_first;
  assign hit      = (ts_count != '0) && (id_r >= ts_first) && (idx < ts_count);

  // restoring divider step
  assign rem_ext = {rem_r, quo_r[SRC_ROW_W-1]};
  assign div_ge  = rem_ext >= {1'b0, cols_r};
  assign rem_sub = rem_ext - {1'b0, cols_r};

  // shared multiply-add for both screen coordinates
  always_comb begin
    if (state_r == ST_MULY) begin
      mul_a   = pos_r.row;
      mul_b   = th_r;
      mul_org = origin_y_r;
    end else begin
      mul_a   = pos_r.col;
      mul_b   = tw_r;
      mul_org = origin_x_r;
    end
  end
  assign mul_sum = SCREEN_W'(mul_org) + $signed({2'b00, 20'(mul_a * mul_b)});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.tile_id != '0) state_nxt = ST_MATCH;
      end
      ST_MATCH: begin
        if (hit) begin
          state_nxt = ST_DIV;
        end else if (scan_r == LAST_TS && slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (step_r == '1) state_nxt = ST_MULX;
      end
      ST_MULX: state_nxt = ST_MULY;
      ST_MULY: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and control strobes
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    load_nm     = (state_r == ST_MATCH) && !hit && (scan_r == LAST_TS) && slot_free;
    load_res    = (state_r == ST_MULY) && slot_free;
    finish      = load_nm || load_res;
  end

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.tileset_sel = out_sel_r;
  assign out_ch.src_col     = out_col_r;
  assign out_ch.src_row     = out_row_r;
  assign out_ch.screen_x    = out_x_r;
  assign out_ch.screen_y    = out_y_r;
  assign out_ch.no_match    = out_nm_r;

  // cell position
  always_comb begin
    base_pos = pos_r;
    pos_nxt  = pos_r;
    if (in_acc) begin
      if (in_ch.restart) base_pos = '0;
      pos_nxt = (in_ch.tile_id == '0) ? tmts_advance(base_pos, eff_w) : base_pos;
    end else if (finish) begin
      pos_nxt = tmts_advance(pos_r, eff_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pos_r         <= '0;
      out_valid_r   <= 1'b0;
      layer_width_r <= WIDTH_W'(1);
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      for (int i = 0; i < TS_REGS; i++) tileset_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        if (cfg_ch.index < REG_LAYER_WIDTH) begin
          tileset_r[cfg_ch.index[SEL_W-1:0]] <= cfg_ch.data;
        end else if (cfg_ch.index == REG_LAYER_WIDTH) begin
          layer_width_r <= cfg_ch.data[WIDTH_W-1:0];
        end else if (cfg_ch.index == REG_LAYER_ORIGIN_X) begin
          origin_x_r <= cfg_ch.data[ORIGIN_W-1:0];
        end else if (cfg_ch.index == REG_LAYER_ORIGIN_Y) begin
          origin_y_r <= cfg_ch.data[ORIGIN_W-1:0];
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r   <= in_ch.tile_id;
      scan_r <= SEL_W'(REG_TILESET0);
    end
    if (state_r == ST_MATCH) begin
      if (hit) begin
        quo_r  <= idx;
        rem_r  <= '0;
        step_r <= '0;
        cols_r <= (ts_cur[39:32] == '0) ? SRC_COL_W'(1) : ts_cur[39:32];
        tw_r   <= ts_cur[47:40];
        th_r   <= ts_cur[55:48];
      end else if (scan_r != LAST_TS) begin
        scan_r <= scan_r + SEL_W'(1);
      end
    end
    if (state_r == ST_DIV) begin
      quo_r  <= {quo_r[SRC_ROW_W-2:0], div_ge};
      rem_r  <= div_ge ? rem_sub[SRC_COL_W-1:0] : rem_ext[SRC_COL_W-1:0];
      step_r <= step_r + 4'd1;
    end
    if (state_r == ST_MULX) sx_r <= mul_sum;
    if (load_res) begin
      out_sel_r <= scan_r;
      out_col_r <= rem_r;
      out_row_r <= quo_r;
      out_x_r   <= sx_r;
      out_y_r   <= mul_sum;
      out_nm_r  <= 1'b0;
    end else if (load_nm) begin
      out_sel_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      out_x_r   <= '0;
      out_y_r   <= '0;
      out_nm_r  <= 1'b1;
    end
  end

endmodule
